### hdl/sfl_pkg.sv
// Package for the sorted list with free list.
// Holds the transfer payload types, operation and status codes, sequencer states
// and the default store depth. No dependencies.
package sfl_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int VAL_W       = 32;
  localparam int COUNT_W     = 5;

  typedef enum logic [1:0] {
    FN_INSERT   = 2'd0,
    FN_RM_HEAD  = 2'd1,
    FN_RM_TAIL  = 2'd2,
    FN_RM_VALUE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_FRESH_D,
    S_WALK_D,
    S_LINK,
    S_LINK_PREV,
    S_UNLINK,
    S_FREE,
    S_HEAD_D,
    S_DONE
  } state_t;

  typedef struct packed {
    func_t                   func;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    status_t                 status;
    logic                    list_empty;
    logic signed [VAL_W-1:0] head_value;
    logic signed [VAL_W-1:0] tail_value;
    logic [COUNT_W-1:0]      entry_count;
  } result_t;

  // Write enables of the node store.
  typedef struct packed {
    logic val_we;
    logic link_we;
  } store_wr_t;

  // Result of the shared comparator.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

### hdl/sfl_cmp.sv
// Shared signed comparator used by the value walks and the tail-value match check.
// Depends on sfl_pkg.
module sfl_cmp (
  input  logic signed [sfl_pkg::VAL_W-1:0] a,
  input  logic signed [sfl_pkg::VAL_W-1:0] b,
  output sfl_pkg::cmp_t                    res
);
  import sfl_pkg::*;

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

### hdl/sfl_store.sv
// Node store: value memory and link memory, one write port and one
// registered read port each, sharing addresses. Depends on sfl_pkg.
module sfl_store #(
  parameter int ENTRIES = sfl_pkg::ENTRIES_DEF
) (
  input  logic                              clk,
  input  sfl_pkg::store_wr_t                wr,
  input  logic [$clog2(ENTRIES)-1:0]        wr_addr,
  input  logic signed [sfl_pkg::VAL_W-1:0]  wr_value,
  input  logic [$clog2(ENTRIES+1)-1:0]      wr_link,
  input  logic [$clog2(ENTRIES)-1:0]        rd_addr,
  output logic signed [sfl_pkg::VAL_W-1:0]  rd_value,
  output logic [$clog2(ENTRIES+1)-1:0]      rd_link
);
  import sfl_pkg::*;

  localparam int IW = $clog2(ENTRIES + 1);

  logic signed [VAL_W-1:0] value_mem [ENTRIES];
  logic [IW-1:0]           link_mem  [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      value_mem[wr_addr] <= wr_value;
    end
    rd_value <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    rd_link <= link_mem[rd_addr];
  end

endmodule

### hdl/sorted_list_with_free_list_core.sv
// Sorted list with free list: top level and operation sequencer. Depends on sfl_pkg,
// sfl_store and sfl_cmp. Per item, one node walked per cycle: insert reads the free node,
// walks, writes the new node and, when linked behind a node, that node's link; a removal hit
// walks, unlinks, frees the node and reads the new head value when the head of a longer list
// goes; a miss only walks; full, empty or tail mismatch go straight to S_DONE. One item at a
// time, next taken the cycle after its result loads. Reset chains the free list, input stalled.
module sorted_list_with_free_list_core #(
  parameter int ENTRIES = sfl_pkg::ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sfl_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sfl_pkg::result_t result
);
  import sfl_pkg::*;

  // AW addresses a node; IW also holds the null index, which equals ENTRIES.
  localparam int            AW  = $clog2(ENTRIES);
  localparam int            IW  = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] NIL = IW'(ENTRIES);

  state_t state, state_next;

  // List bookkeeping.
  logic [IW-1:0]           head_idx;
  logic [IW-1:0]           tail_idx;
  logic [IW-1:0]           free_head;
  logic [IW-1:0]           total;
  logic signed [VAL_W-1:0] head_val;
  logic signed [VAL_W-1:0] tail_val;

  // Per-item working registers.
  logic [IW-1:0]           init_cnt;
  logic [IW-1:0]           cur;
  logic [IW-1:0]           prev;
  logic [IW-1:0]           nxt;
  logic [IW-1:0]           fresh;
  logic signed [VAL_W-1:0] prev_val;
  logic signed [VAL_W-1:0] v_r;
  func_t                   func_r;
  status_t                 status_r;

  // Store and comparator hookup.
  store_wr_t               wr;
  logic [AW-1:0]           wr_addr;
  logic signed [VAL_W-1:0] wr_value;
  logic [IW-1:0]           wr_link;
  logic [AW-1:0]           rd_addr;
  logic signed [VAL_W-1:0] rd_value;
  logic [IW-1:0]           rd_link;
  logic signed [VAL_W-1:0] cmp_a;
  logic signed [VAL_W-1:0] cmp_b;
  cmp_t                    cmp;

  // Walk decisions, valid in S_WALK_D where the store shows node cur.
  logic hit;
  logic advance;
  logic result_free;

  sfl_store #(.ENTRIES(ENTRIES)) u_store (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_value (wr_value),
    .wr_link  (wr_link),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_link  (rd_link)
  );

  sfl_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp)
  );

  // An item is taken only while the sequencer idles; the result register lets the
  // next transfer in while an earlier result still waits downstream.
  assign item_stall  = (state != S_IDLE);
  assign result_free = !result_valid || !result_stall;

  // Remove-tail looks for the tail node by index to learn its predecessor; the other
  // removals compare with the value: remove-value looks for the first equal value, remove-head
  // checks the head only. Insert never hits: it stops at the first node that is not smaller.
  assign hit = (func_r == FN_RM_TAIL) ? (cur == tail_idx)
                                      : ((func_r != FN_INSERT) && cmp.eq);
  assign advance = (func_r == FN_INSERT) ? cmp.lt
                 : (((func_r == FN_RM_TAIL) || (func_r == FN_RM_VALUE)) && !hit);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (init_cnt == IW'(ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          unique case (item.func)
            FN_INSERT:   state_next = (free_head == NIL) ? S_DONE : S_FRESH_D;
            FN_RM_TAIL:  state_next = ((tail_idx == NIL) || !cmp.eq) ? S_DONE : S_WALK_D;
            FN_RM_HEAD:  state_next = (head_idx == NIL) ? S_DONE : S_WALK_D;
            FN_RM_VALUE: state_next = (head_idx == NIL) ? S_DONE : S_WALK_D;
          endcase
        end
      end
      S_FRESH_D: state_next = (cur == NIL) ? S_LINK : S_WALK_D;
      S_WALK_D: begin
        if (hit) begin
          state_next = S_UNLINK;
        end else if (advance && (rd_link != NIL)) begin
          state_next = S_WALK_D;
        end else begin
          state_next = (func_r == FN_INSERT) ? S_LINK : S_DONE;
        end
      end
      S_LINK:      state_next = (prev == NIL) ? S_DONE : S_LINK_PREV;
      S_LINK_PREV: state_next = S_DONE;
      S_UNLINK:    state_next = S_FREE;
      S_FREE:      state_next = ((prev == NIL) && (nxt != NIL)) ? S_HEAD_D : S_DONE;
      S_HEAD_D:    state_next = S_DONE;
      S_DONE: begin
        if (result_free) begin
          state_next = S_IDLE;
        end
      end
      default:     state_next = S_INIT;
    endcase
  end

  // Store and comparator controls for each state.
  always_comb begin
    wr       = '0;
    wr_addr  = init_cnt[AW-1:0];
    wr_value = v_r;
    wr_link  = '0;
    rd_addr  = cur[AW-1:0];
    cmp_a    = rd_value;
    cmp_b    = v_r;
    unique case (state) inside
      S_INIT: begin
        // Node i links to i + 1; the last node links to null.
        wr.link_we = 1'b1;
        wr_addr    = init_cnt[AW-1:0];
        wr_link    = init_cnt + IW'(1);
      end
      S_IDLE: begin
        // Start the first read early: the free node for insert, the head otherwise.
        // The tail match of remove-tail is settled here against the held tail value.
        rd_addr = (item.func == FN_INSERT) ? free_head[AW-1:0] : head_idx[AW-1:0];
        cmp_a   = tail_val;
        cmp_b   = item.value;
      end
      S_FRESH_D: rd_addr = cur[AW-1:0];
      S_WALK_D:  rd_addr = rd_link[AW-1:0];
      S_LINK: begin
        wr.val_we  = 1'b1;
        wr.link_we = 1'b1;
        wr_addr    = fresh[AW-1:0];
        wr_link    = cur;
      end
      S_LINK_PREV: begin
        wr.link_we = 1'b1;
        wr_addr    = prev[AW-1:0];
        wr_link    = fresh;
      end
      S_UNLINK: begin
        wr.link_we = (prev != NIL);
        wr_addr    = prev[AW-1:0];
        wr_link    = nxt;
      end
      S_FREE: begin
        // Push the freed node on the free list and fetch the new head's value.
        wr.link_we = 1'b1;
        wr_addr    = cur[AW-1:0];
        wr_link    = free_head;
        rd_addr    = nxt[AW-1:0];
      end
      S_HEAD_D, S_DONE: begin
        rd_addr = cur[AW-1:0];
      end
      default: begin
        rd_addr = cur[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // The result register fills when an item finishes and empties on its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_DONE) && result_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // List bookkeeping and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt     <= '0;
      head_idx     <= NIL;
      tail_idx     <= NIL;
      free_head    <= '0;
      total        <= '0;
    end else begin
      unique case (state)
        S_INIT: init_cnt <= init_cnt + IW'(1);
        S_IDLE: begin
          if (item_valid) begin
            func_r   <= item.func;
            v_r      <= item.value;
            cur      <= head_idx;
            prev     <= NIL;
            fresh    <= free_head;
            unique case (item.func) inside
              FN_INSERT: begin
                status_r <= (free_head == NIL) ? STS_FULL : STS_OK;
              end
              FN_RM_TAIL: begin
                status_r <= ((tail_idx == NIL) || !cmp.eq) ? STS_NOT_FOUND : STS_OK;
              end
              FN_RM_HEAD, FN_RM_VALUE: begin
                status_r <= (head_idx == NIL) ? STS_NOT_FOUND : STS_OK;
              end
            endcase
          end
        end
        S_FRESH_D: free_head <= rd_link;
        S_WALK_D: begin
          if (hit) begin
            nxt <= rd_link;
          end else if (advance) begin
            prev     <= cur;
            prev_val <= rd_value;
            cur      <= rd_link;
            if ((rd_link == NIL) && (func_r != FN_INSERT)) begin
              status_r <= STS_NOT_FOUND;
            end
          end else if (func_r != FN_INSERT) begin
            status_r <= STS_NOT_FOUND;
          end
        end
        S_LINK: begin
          if (prev == NIL) begin
            head_idx <= fresh;
            head_val <= v_r;
          end
          if (cur == NIL) begin
            tail_idx <= fresh;
            tail_val <= v_r;
          end
          total <= total + IW'(1);
        end
        S_UNLINK: begin
          if (prev == NIL) begin
            head_idx <= nxt;
          end
          if (tail_idx == cur) begin
            tail_idx <= prev;
            tail_val <= prev_val;
          end
        end
        S_FREE: begin
          free_head <= cur;
          total     <= total - IW'(1);
        end
        S_HEAD_D: head_val <= rd_value;
        S_DONE: begin
          if (result_free) begin
            result.status      <= status_r;
            result.list_empty  <= (head_idx == NIL);
            result.head_value  <= (head_idx == NIL) ? '0 : head_val;
            result.tail_value  <= (head_idx == NIL) ? '0 : tail_val;
            result.entry_count <= COUNT_W'(total);
          end
        end
        S_LINK_PREV: begin
          fresh <= fresh;
        end
        default: begin
          init_cnt <= '0;
        end
      endcase
    end
  end

  // The count never goes past the store depth.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= IW'(ENTRIES))
    else $error("node count exceeds store depth");

  // Between items an empty list has null head and tail and a zero count.
  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (((head_idx == NIL) == (total == '0)) &&
                           ((tail_idx == NIL) == (head_idx == NIL))))
    else $error("head, tail and count disagree on an empty list");

  // Between items an exhausted free list means a full store.
  a_free_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((free_head == NIL) == (total == IW'(ENTRIES))))
    else $error("free list and count disagree");

  // A full status is reported only when no node was free.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && (status_r == STS_FULL)) |-> (free_head == NIL))
    else $error("full status with a free node left");

  // A finished item always lands in the result register when it leaves S_DONE.
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && result_free) |=> (result_valid && (state == S_IDLE)))
    else $error("result not loaded at the end of an item");

endmodule
